@@ sv/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared shorthand for clocked concurrent assertions, with or without a reset guard.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge while the reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checks prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ sv/bdq_pkg.sv @@
// ============================================================================
// Deque package
// Request and result types, command and status codes and cell operations.
// ============================================================================
`timescale 1ns / 1ps

package bdq_pkg;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_COUNT      = 3'd4;
    localparam logic [2:0] CMD_REMOVE     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_SHR   = 3'd1,
        OP_SHL   = 3'd2,
        OP_ROT   = 3'd3,
        OP_LOAD  = 3'd4
    } t_cell_op;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [6:0]         match_count;
        logic [6:0]         occupancy;
    } t_result;

endpackage

@@ sv/bdq_cell.sv @@
// ============================================================================
// Deque cell
// One storage position of the chain; shifts, rotates or loads on command.
// ============================================================================
`timescale 1ns / 1ps

module bdq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int LEN_WIDTH  = 7,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  bdq_pkg::t_cell_op     i_op,
    input  logic [LEN_WIDTH-1:0]  i_len,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_head,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  is_tail;
    logic                  is_next;

    assign is_tail = (i_len == LEN_WIDTH'(IDX + 1));
    assign is_next = (i_len == LEN_WIDTH'(IDX));

    always_comb begin
        n_data = r_data;
        case (i_op)
            bdq_pkg::OP_SHR:  n_data = i_left;
            bdq_pkg::OP_SHL:  n_data = i_right;
            bdq_pkg::OP_ROT:  n_data = is_tail ? i_head : i_right;
            bdq_pkg::OP_LOAD: n_data = is_next ? i_value : r_data;
            default:          n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ sv/bounded_deque_with_search.sv @@
// ============================================================================
// Bounded deque with search
// Ordered store of up to DEPTH values held in a chain of shifting cells.
// ============================================================================
// A request is taken at a rising edge with start high and busy low. Exactly
// one result follows, shown for one cycle with o_result_valid high; the
// receiver cannot hold it off, so it must take it in that cycle.
// Between requests the front entry sits in the first cell. Pushes and a pop
// from the front finish in the cycle of the request and the result appears
// in the next cycle, with busy staying low, so such requests may follow back to back.
// Pop from the back, count and remove rotate the occupied part of the chain
// once past the first cell, one position per cycle: they keep busy high
// until every entry has passed, and the result appears in the cycle after
// the last step. With an empty store they finish at once.
// The rotation through the chain is what sets the length of these requests,
// so they take longer the fuller the store is.
// Reset empties the store and drops busy and the result strobe; the stored
// data themselves are not cleared.
// ============================================================================
`timescale 1ns / 1ps

module bounded_deque_with_search #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bdq_pkg::t_request  i_request,
    output logic               o_result_valid,
    output bdq_pkg::t_result   o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                r_state,  n_state;
    logic [CW-1:0]         r_count,  n_count;
    logic [CW-1:0]         r_left,   n_left;
    logic [CW-1:0]         r_match,  n_match;
    logic [2:0]            r_cmd,    n_cmd;
    logic [DATA_WIDTH-1:0] r_value,  n_value;
    logic                  r_found,  n_found;
    logic                  r_valid,  n_valid;
    bdq_pkg::t_result      r_result, n_result;

    bdq_pkg::t_cell_op     cell_op;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] head;
    logic [DATA_WIDTH-1:0] in_value;
    logic [31:0]           head_out;
    logic                  accept;
    logic                  hit;
    logic                  last_step;

    assign head = cell_data[0];

    generate
        if (DATA_WIDTH > 32) begin : g_wide
            assign in_value = {{(DATA_WIDTH - 32){i_request.value[31]}}, i_request.value};
            assign head_out = head[31:0];
        end else if (DATA_WIDTH == 32) begin : g_equal
            assign in_value = i_request.value;
            assign head_out = head;
        end else begin : g_narrow
            assign in_value = i_request.value[DATA_WIDTH-1:0];
            assign head_out = {{(32 - DATA_WIDTH){head[DATA_WIDTH-1]}}, head};
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;

            if (gi == 0) begin : g_first
                assign left_data = in_value;
            end else begin : g_left
                assign left_data = cell_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_end
                assign right_data = cell_data[gi];
            end else begin : g_right
                assign right_data = cell_data[gi+1];
            end

            bdq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .LEN_WIDTH  (CW),
                .IDX        (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op),
                .i_len   (r_count),
                .i_left  (left_data),
                .i_right (right_data),
                .i_head  (head),
                .i_value (in_value),
                .o_data  (cell_data[gi])
            );
        end
    endgenerate

    assign busy      = (r_state == S_SCAN);
    assign accept    = start && !busy;
    assign hit       = (head == r_value);
    assign last_step = (r_left == CW'(1));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_match  = r_match;
        n_cmd    = r_cmd;
        n_value  = r_value;
        n_found  = r_found;
        n_valid  = 1'b0;
        n_result = r_result;
        cell_op  = bdq_pkg::OP_HOLD;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd                 = i_request.cmd;
                    n_value               = in_value;
                    n_found               = 1'b0;
                    n_match               = '0;
                    n_left                = r_count;
                    n_result.status       = bdq_pkg::ST_OK;
                    n_result.popped_value = '0;
                    n_result.match_count  = '0;
                    n_valid               = 1'b1;
                    case (i_request.cmd)
                        bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_result.status = bdq_pkg::ST_FULL;
                            end else begin
                                cell_op = (i_request.cmd == bdq_pkg::CMD_PUSH_FRONT)
                                        ? bdq_pkg::OP_SHR : bdq_pkg::OP_LOAD;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bdq_pkg::CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_result.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                cell_op               = bdq_pkg::OP_SHL;
                                n_result.popped_value = head_out;
                                n_count               = r_count - CW'(1);
                            end
                        end
                        bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_result.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        bdq_pkg::CMD_COUNT: begin
                            if (r_count != '0) begin
                                n_valid = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_result.status = bdq_pkg::ST_OK;
                        end
                    endcase
                    n_result.occupancy = 7'(n_count);
                end
            end
            S_SCAN: begin
                n_left = r_left - CW'(1);
                case (r_cmd)
                    bdq_pkg::CMD_POP_BACK: begin
                        if (last_step) begin
                            cell_op               = bdq_pkg::OP_SHL;
                            n_count               = r_count - CW'(1);
                            n_result.popped_value = head_out;
                        end else begin
                            cell_op = bdq_pkg::OP_ROT;
                        end
                    end
                    bdq_pkg::CMD_COUNT: begin
                        cell_op = bdq_pkg::OP_ROT;
                        n_match = r_match + CW'(hit);
                    end
                    default: begin
                        if (hit && !r_found) begin
                            cell_op = bdq_pkg::OP_SHL;
                            n_count = r_count - CW'(1);
                            n_found = 1'b1;
                        end else begin
                            cell_op = bdq_pkg::OP_ROT;
                        end
                    end
                endcase
                if (last_step) begin
                    n_state              = S_IDLE;
                    n_valid              = 1'b1;
                    n_result.match_count = 7'(n_match);
                    n_result.occupancy   = 7'(n_count);
                    n_result.status      = (r_cmd == bdq_pkg::CMD_REMOVE && !n_found)
                                         ? bdq_pkg::ST_NOT_FOUND : bdq_pkg::ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_match  <= n_match;
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_found  <= n_found;
        r_result <= n_result;
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule

@@ sv/bdq_checker.sv @@
// ============================================================================
// Deque port checker
// Watches the ports of the deque for results that do not fit its requests.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker #(
    parameter int DEPTH = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input bdq_pkg::t_request i_request,
    input logic              o_result_valid,
    input bdq_pkg::t_result  o_result
);

    `ASSERT_CLK(a_result_has_request, i_clk, i_rst_n, o_result_valid |-> $past(start && !busy) || $past(busy))
    `ASSERT_CLK(a_busy_after_request, i_clk, i_rst_n, $rose(busy) |-> $past(start))
    `ASSERT_CLK(a_full_occupancy, i_clk, i_rst_n, (o_result_valid && o_result.status == bdq_pkg::ST_FULL) |-> o_result.occupancy == 7'(DEPTH))
    `ASSERT_CLK(a_empty_occupancy, i_clk, i_rst_n, (o_result_valid && o_result.status == bdq_pkg::ST_EMPTY) |-> o_result.occupancy == 7'd0 && o_result.popped_value == 32'sd0)
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !busy && !o_result_valid)

endmodule

bind bounded_deque_with_search bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_request      (i_request),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

@@ verif/testbench.sv @@
// ============================================================================
// Bounded deque with search: testbench
// Drives push, pop, count and remove requests into the deque and compares
// each result with a shadow copy of the ordered contents, kept in a queue.
// A short directed part covers the empty and not-found cases, the
// removal of front and middle entries and the unused command codes.
// A long random part then fills, drains and searches the store in phases.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH        = 64;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_TAIL    = 200;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_SEARCH
    } t_mode;

    class deque_shadow;
        logic [31:0]      shadow_entries[$];
        bdq_pkg::t_result pending_replies[$];
        int               failures;

        function void note_request(bdq_pkg::t_request req);
            bdq_pkg::t_result reply;
            int               hit;
            reply = '0;
            case (req.cmd)
                bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                    if (shadow_entries.size() >= DEPTH) begin
                        reply.status = bdq_pkg::ST_FULL;
                    end else if (req.cmd == bdq_pkg::CMD_PUSH_FRONT) begin
                        shadow_entries.push_front(req.value);
                    end else begin
                        shadow_entries.push_back(req.value);
                    end
                end
                bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
                    if (shadow_entries.size() == 0) begin
                        reply.status = bdq_pkg::ST_EMPTY;
                    end else if (req.cmd == bdq_pkg::CMD_POP_FRONT) begin
                        reply.popped_value = shadow_entries.pop_front();
                    end else begin
                        reply.popped_value = shadow_entries.pop_back();
                    end
                end
                bdq_pkg::CMD_COUNT: begin
                    foreach (shadow_entries[i]) begin
                        if (shadow_entries[i] == req.value) begin
                            reply.match_count = reply.match_count + 7'd1;
                        end
                    end
                end
                bdq_pkg::CMD_REMOVE: begin
                    hit = -1;
                    foreach (shadow_entries[i]) begin
                        if (hit < 0 && shadow_entries[i] == req.value) begin
                            hit = i;
                        end
                    end
                    if (shadow_entries.size() == 0) begin
                        reply.status = bdq_pkg::ST_EMPTY;
                    end else if (hit < 0) begin
                        reply.status = bdq_pkg::ST_NOT_FOUND;
                    end else begin
                        shadow_entries.delete(hit);
                    end
                end
                default: begin
                end
            endcase
            reply.occupancy = 7'(shadow_entries.size());
            pending_replies.push_back(reply);
        endfunction

        function void check_result(bdq_pkg::t_result got);
            bdq_pkg::t_result want;
            if (pending_replies.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.popped_value !== want.popped_value) begin
                $error("popped_value: expected %0d, actual %0d",
                       want.popped_value, got.popped_value);
                failures++;
            end
            if (got.match_count !== want.match_count) begin
                $error("match_count: expected %0d, actual %0d",
                       want.match_count, got.match_count);
                failures++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d",
                       want.occupancy, got.occupancy);
                failures++;
            end
        endfunction

        function logic [31:0] stored_or_random();
            if (shadow_entries.size() == 0 || $urandom_range(0, 3) == 0) begin
                return $urandom;
            end
            return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    bdq_pkg::t_request i_request;
    logic              o_result_valid;
    bdq_pkg::t_result  o_result;

    deque_shadow sb;

    bounded_deque_with_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                sb.check_result(o_result);
            end
            if (start && !busy) begin
                sb.note_request(i_request);
            end
        end
    end

    task automatic send_request(input logic [2:0] cmd, input logic [31:0] value);
        @(negedge i_clk);
        start     <= 1'b1;
        i_request <= '{cmd: cmd, value: value};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_for_replies();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] pool_base,
                                                input int pool_span);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom;
            default: return pool_base + 32'($urandom_range(0, pool_span));
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd(input t_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 45) return bdq_pkg::CMD_PUSH_FRONT;
                if (r < 90) return bdq_pkg::CMD_PUSH_BACK;
                if (r < 93) return bdq_pkg::CMD_POP_FRONT;
                if (r < 95) return bdq_pkg::CMD_POP_BACK;
                if (r < 98) return bdq_pkg::CMD_COUNT;
                return bdq_pkg::CMD_REMOVE;
            end
            MODE_DRAIN: begin
                if (r < 10) return bdq_pkg::CMD_PUSH_FRONT;
                if (r < 20) return bdq_pkg::CMD_PUSH_BACK;
                if (r < 55) return bdq_pkg::CMD_POP_FRONT;
                if (r < 85) return bdq_pkg::CMD_POP_BACK;
                if (r < 92) return bdq_pkg::CMD_COUNT;
                if (r < 99) return bdq_pkg::CMD_REMOVE;
                return CMD_SPARE_6;
            end
            MODE_MIXED: begin
                if (r < 20) return bdq_pkg::CMD_PUSH_FRONT;
                if (r < 40) return bdq_pkg::CMD_PUSH_BACK;
                if (r < 55) return bdq_pkg::CMD_POP_FRONT;
                if (r < 70) return bdq_pkg::CMD_POP_BACK;
                if (r < 82) return bdq_pkg::CMD_COUNT;
                if (r < 97) return bdq_pkg::CMD_REMOVE;
                return (r < 99) ? CMD_SPARE_6 : CMD_SPARE_7;
            end
            default: begin
                if (r < 15) return bdq_pkg::CMD_PUSH_FRONT;
                if (r < 30) return bdq_pkg::CMD_PUSH_BACK;
                if (r < 35) return bdq_pkg::CMD_POP_FRONT;
                if (r < 40) return bdq_pkg::CMD_POP_BACK;
                if (r < 70) return bdq_pkg::CMD_COUNT;
                return bdq_pkg::CMD_REMOVE;
            end
        endcase
    endfunction

    initial begin
        #1_500_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_mode       mode;
        int          issued;
        int          phase_left;
        int          pool_span;
        bit          idle_on;
        bit          drained_mid;
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [31:0] pool_base;

        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_request   = '0;
        drained_mid = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(bdq_pkg::CMD_POP_FRONT,  32'd0);
        send_request(bdq_pkg::CMD_POP_BACK,   32'd0);
        send_request(bdq_pkg::CMD_COUNT,      32'd0);
        send_request(bdq_pkg::CMD_REMOVE,     32'd0);
        send_request(bdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(bdq_pkg::CMD_PUSH_BACK,  32'h8000_0000);
        send_request(bdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::CMD_PUSH_BACK,  32'hFFFF_FFFF);
        send_request(bdq_pkg::CMD_PUSH_BACK,  32'd5);
        send_request(bdq_pkg::CMD_PUSH_FRONT, 32'd5);
        send_request(bdq_pkg::CMD_COUNT,      32'd5);
        send_request(bdq_pkg::CMD_COUNT,      32'hFFFF_FFFF);
        send_request(bdq_pkg::CMD_COUNT,      32'h8000_0000);
        send_request(bdq_pkg::CMD_REMOVE,     32'd123);
        send_request(bdq_pkg::CMD_REMOVE,     32'd5);
        send_request(bdq_pkg::CMD_REMOVE,     32'h8000_0000);
        send_request(CMD_SPARE_6,             32'd5);
        send_request(CMD_SPARE_7,             32'hFFFF_FFFF);
        send_request(bdq_pkg::CMD_POP_BACK,   32'd0);
        send_request(bdq_pkg::CMD_POP_FRONT,  32'd0);
        send_request(bdq_pkg::CMD_REMOVE,     32'd5);
        send_request(bdq_pkg::CMD_POP_FRONT,  32'd0);
        send_request(bdq_pkg::CMD_POP_BACK,   32'd0);
        wait_for_replies();

        issued     = 0;
        phase_left = 0;
        mode       = MODE_FILL;
        pool_base  = 32'd0;
        pool_span  = 3;
        idle_on    = 1'b0;
        while (issued < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                mode       = t_mode'($urandom_range(0, 3));
                phase_left = $urandom_range(60, 120);
                pool_base  = $urandom;
                pool_span  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15);
                idle_on    = ($urandom_range(0, 2) != 0);
            end
            if (!drained_mid && issued >= RANDOM_ITEMS / 2) begin
                wait_for_replies();
                drained_mid = 1'b1;
            end
            cmd = pick_cmd(mode);
            if ((cmd == bdq_pkg::CMD_COUNT || cmd == bdq_pkg::CMD_REMOVE)
                    && $urandom_range(0, 1) == 1) begin
                value = sb.stored_or_random();
            end else begin
                value = pick_value(pool_base, pool_span);
            end
            if (idle_on && issued < RANDOM_ITEMS - CALM_TAIL
                    && $urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 9));
            end
            send_request(cmd, value);
            phase_left--;
            if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) begin
                issued++;
            end
        end

        wait_for_replies();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (sb.pending_replies.size() != 0) begin
            $error("%0d results never arrived", sb.pending_replies.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/bdq_pkg.sv
sv/bdq_cell.sv
sv/bounded_deque_with_search.sv
sv/bdq_checker.sv
verif/testbench.sv
